>>> hw/rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared constants and helpers for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

   // one BCD digit
   localparam int DIGIT_BITS = 4;

   // width of the ASCII digit field
   localparam int CHAR_BITS = 6;

   // '0'..'9' are 0x30..0x39: upper two bits of the 6-bit code are fixed
   localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

   // decimal digits needed for the largest value of the given bit width:
   // floor(bits * log10(2)) + 1, with log10(2) ~ 1233 / 4096
   function automatic int digits_for(input int bits);
      return ((bits * 1233) >> 12) + 1;
   endfunction

endpackage

>>> hw/rtl/bda_channels.sv
// ----------------------------------------------------------------------------
// bda_channels
// Valid/ready channels for the request (binary value) and the response
// (one ASCII digit per item).
// ----------------------------------------------------------------------------
interface bda_req_if #(parameter int VALUE_BITS = 32) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface bda_rsp_if import bda_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] digit_char;
   logic                 last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> hw/rtl/bda_dabble.sv
// ----------------------------------------------------------------------------
// bda_dabble
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module bda_dabble import bda_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int NDIG       = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   bda_req_if.sink                    req_if,
   output logic                       bcd_valid,
   input  logic                       bcd_ready,
   output logic [NDIG*DIGIT_BITS-1:0] bcd
);

   localparam int BCD_BITS = NDIG * DIGIT_BITS;
   localparam int CW       = $clog2(VALUE_BITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
            adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               bin_in   = req_if.value;
               bcd_in   = '0;
               cnt_in   = CW'(VALUE_BITS);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            bcd_in = {adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (bcd_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign bcd_valid    = (state_ff == ST_DONE);
   assign bcd          = bcd_ff;

   function automatic logic digits_ok(input logic [BCD_BITS-1:0] b);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < NDIG; i++) begin
         if (b[i*DIGIT_BITS +: DIGIT_BITS] > 4'd9) ok = 1'b0;
      end
      return ok;
   endfunction

   // every digit stays decimal while shifting and while handed off
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_DONE) |-> digits_ok(bcd_ff))
      else $error("BCD digit out of range");

   // the final shift leads straight to the handoff
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff == CW'(1)) |=> (state_ff == ST_DONE))
      else $error("conversion did not finish on its last bit");

   // a new value is taken only once the last result left this unit
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !bcd_ready) |=> (state_ff == ST_DONE))
      else $error("converted value dropped before handoff");

endmodule

>>> hw/rtl/bda_emit.sv
// ----------------------------------------------------------------------------
// bda_emit
// Digit serializer: drops leading zeros, then sends one ASCII digit per
// item, most significant first, through an output register.
// ----------------------------------------------------------------------------
module bda_emit import bda_pkg::*; #(
   parameter int NDIG = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       bcd_valid,
   output logic                       bcd_ready,
   input  logic [NDIG*DIGIT_BITS-1:0] bcd,
   bda_rsp_if.source                  rsp_if
);

   localparam int BCD_BITS = NDIG * DIGIT_BITS;
   localparam int LW       = $clog2(NDIG + 1);

   logic [BCD_BITS-1:0]   dig_ff, dig_in;
   logic [LW-1:0]         left_ff, left_in;
   logic                  skip_ff, skip_in;
   logic                  oval_ff, oval_in;
   logic [DIGIT_BITS-1:0] ochr_ff, ochr_in;
   logic                  olast_ff, olast_in;
   logic [DIGIT_BITS-1:0] top;
   logic                  slot_free;

   assign top       = dig_ff[BCD_BITS-1 -: DIGIT_BITS];
   assign slot_free = !oval_ff || rsp_if.ready;
   assign bcd_ready = (left_ff == '0);

   always_comb begin
      dig_in   = dig_ff;
      left_in  = left_ff;
      skip_in  = skip_ff;
      oval_in  = oval_ff && !rsp_if.ready;
      ochr_in  = ochr_ff;
      olast_in = olast_ff;
      if (left_ff == '0) begin
         if (bcd_valid) begin
            dig_in  = bcd;
            left_in = LW'(NDIG);
            skip_in = 1'b1;
         end
      end else if (skip_ff && top == '0 && left_ff != LW'(1)) begin
         // drop a leading zero
         dig_in  = dig_ff << DIGIT_BITS;
         left_in = left_ff - 1'b1;
      end else if (slot_free) begin
         dig_in   = dig_ff << DIGIT_BITS;
         left_in  = left_ff - 1'b1;
         skip_in  = 1'b0;
         oval_in  = 1'b1;
         ochr_in  = top;
         olast_in = (left_ff == LW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         skip_ff <= 1'b0;
         oval_ff <= 1'b0;
      end else begin
         left_ff <= left_in;
         skip_ff <= skip_in;
         oval_ff <= oval_in;
      end
      dig_ff   <= dig_in;
      ochr_ff  <= ochr_in;
      olast_ff <= olast_in;
   end

   assign rsp_if.valid      = oval_ff;
   assign rsp_if.digit_char = {ASCII_DIGIT_HI, ochr_ff};
   assign rsp_if.last_digit = olast_ff;

   // leading-zero mode never outlives the run
   a_skip_in_run: assert property (@(posedge clock) disable iff (reset)
      (left_ff == '0) |-> !skip_ff)
      else $error("leading-zero mode with no digits left");

endmodule

>>> hw/rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII text, one digit per result item.
// ----------------------------------------------------------------------------
// Each request item carries one unsigned VALUE_BITS-bit value. The block
// answers with its decimal digits as ASCII codes '0'..'9', most significant
// first, without leading zeros; zero gives a single '0'. last_digit marks
// the final digit of each run. A value passes through the shift-and-add-3
// converter (one input bit per cycle), a handoff, then the serializer,
// which steps through the decimal digit positions (leading zeros are
// dropped one per cycle) and sends the remaining digits as ASCII. The
// converter takes the next value while the serializer still sends the
// digits of the previous one. Items are independent; no state carries
// from one to the next.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bda_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   bda_req_if.sink    req_if,
   bda_rsp_if.source  rsp_if
);

   // digit count for the widest value
   localparam int NDIG = digits_for(VALUE_BITS);

   logic                       bcd_valid;
   logic                       bcd_ready;
   logic [NDIG*DIGIT_BITS-1:0] bcd;

   // binary to BCD, one bit per cycle; holds the result until the
   // serializer takes it
   bda_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NDIG       (NDIG)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .bcd_valid (bcd_valid),
      .bcd_ready (bcd_ready),
      .bcd       (bcd)
   );

   // drop leading zeros, then advance one digit per response item
   bda_emit #(
      .NDIG (NDIG)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .bcd_valid (bcd_valid),
      .bcd_ready (bcd_ready),
      .bcd       (bcd),
      .rsp_if    (rsp_if)
   );

endmodule

>>> tb/sv/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Self-checking testbench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Feeds 32-bit values over the request channel and checks every ASCII digit
// on the response channel, in order, against typed table text or a local
// division predictor, including the flag on the final digit. A short table
// of edge values runs first, then random values biased toward digit-count
// boundaries, under three pacing profiles for the two sides of the handshake.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii import bda_pkg::*; ();

   localparam int VALUE_BITS       = 32;
   localparam int MAX_DIGITS       = 10;
   localparam int DIRECTED_ROWS    = 20;
   localparam int RANDOM_PER_PHASE = 70;
   localparam int STALL_LIMIT      = 3000;
   localparam int TAIL_CYCLES      = 60;
   localparam int MAX_REPORTS      = 10;

   // idle percentages per pacing phase: receiver-heavy, sender-heavy, none
   localparam int SEND_IDLE [3] = '{35, 63, 0};
   localparam int RSP_IDLE  [3] = '{63, 35, 0};

   typedef struct packed {
      logic [CHAR_BITS-1:0] digit_char;
      logic                 last_digit;
   } digit_type;

   logic clock = 1'b0;
   logic reset;

   bda_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   bda_rsp_if                            rsp_ch ();

   binary_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // digits still owed by the block, oldest first
   digit_type digit_queue [$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int mismatch_count = 0;
   int values_sent = 0;
   int digits_checked = 0;
   int stall_cycles = 0;
   logic [MAX_DIGITS:1] lengths_seen = '0;

   // Directed table: an empty text means the predictor supplies the digits.
   logic [VALUE_BITS-1:0] directed_value [DIRECTED_ROWS] = '{
      32'd0,          32'd1,          32'd9,          32'd10,
      32'd4294967295, 32'd4294967294, 32'd1000000000, 32'd999999999,
      32'd99,         32'd100,        32'd2147483648, 32'd2147483647,
      32'hAAAAAAAA,   32'h55555555,   32'd1234567890, 32'd65535,
      32'd65536,      32'd4000000000, 32'd101,        32'd0
   };
   string directed_text [DIRECTED_ROWS] = '{
      "0",            "1",            "9",            "10",
      "4294967295",   "",             "1000000000",   "999999999",
      "",             "",             "",             "",
      "",             "",             "1234567890",   "",
      "",             "",             "",             "0"
   };

   // Toggle the clock every half period; the period is 4 ns.
   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Queue the decimal digits of a value, most significant first, by
   // repeated division; zero still yields a single '0'.
   function automatic void push_decimal_digits(input logic [VALUE_BITS-1:0] number);
      digit_type   run [$];
      logic [63:0] rest;
      logic [3:0]  bcd;
      rest = 64'(number);
      do begin
         bcd = 4'(rest % 10);
         run.push_front(digit_type'{digit_char: {ASCII_DIGIT_HI, bcd}, last_digit: 1'b0});
         rest = rest / 10;
      end while (rest != 0);
      run[run.size()-1].last_digit = 1'b1;
      lengths_seen[run.size()] = 1'b1;
      foreach (run[k]) digit_queue.push_back(run[k]);
   endfunction

   // Queue digits typed into the table as text.
   function automatic void push_typed_digits(input string text);
      for (int k = 0; k < text.len(); k++) begin
         digit_queue.push_back(digit_type'{digit_char: CHAR_BITS'(text[k]),
                                           last_digit: (k == text.len() - 1)});
      end
      lengths_seen[text.len()] = 1'b1;
   endfunction

   function automatic longint unsigned pow10(input int exponent);
      longint unsigned acc;
      acc = 1;
      for (int k = 0; k < exponent; k++) acc = acc * 10;
      return acc;
   endfunction

   // Draw a random value: uniform, by digit count, under 100, one bit set or
   // clear, powers of ten, their neighbors, or the top of the range.
   function automatic logic [VALUE_BITS-1:0] pick_value();
      longint unsigned lo;
      longint unsigned hi;
      int              ndig;
      unique case ($urandom_range(9))
         0, 1, 2: return $urandom;
         3:       return VALUE_BITS'(pow10($urandom_range(9)));
         4:       return VALUE_BITS'(pow10($urandom_range(9, 1)) - 1);
         5:       return $urandom_range(99);
         6: begin
            ndig = $urandom_range(MAX_DIGITS, 1);
            lo = pow10(ndig - 1);
            hi = (ndig == MAX_DIGITS) ? 64'hFFFF_FFFF : pow10(ndig) - 1;
            return $urandom_range(hi[31:0], lo[31:0]);
         end
         7: begin
            lo = 64'd1 << $urandom_range(VALUE_BITS - 1);
            return $urandom_range(1) ? ~VALUE_BITS'(lo) : VALUE_BITS'(lo);
         end
         8:       return 32'hFFFF_FFFF - $urandom_range(255);
         default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one value and record its digits once the block accepts it. With
   // drain set, drop valid and hold off until every owed digit has come.
   task automatic send_value(input logic [VALUE_BITS-1:0] number, input string text,
                             input bit drain);
      if (drain) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (digit_queue.size() != 0) @(posedge clock);
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= number;
      do @(posedge clock); while (!req_ch.ready);
      // accepted at this edge; valid stays high unless the next call drops it
      if (text.len() > 0) push_typed_digits(text);
      else                push_decimal_digits(number);
      values_sent++;
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Stall the receiver at random by the current phase's idle percentage.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // Check each accepted digit against the oldest owed one and track
   // handshake activity for the watchdog.
   always @(posedge clock) begin
      digit_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (digit_queue.size() == 0) begin
            report_mismatch($sformatf("digit_char %0d last_digit %0d with no digit owed",
                                      rsp_ch.digit_char, rsp_ch.last_digit));
         end else begin
            want = digit_queue.pop_front();
            digits_checked++;
            if (rsp_ch.digit_char !== want.digit_char)
               report_mismatch($sformatf("digit_char expected %0d got %0d",
                                         want.digit_char, rsp_ch.digit_char));
            if (rsp_ch.last_digit !== want.last_digit)
               report_mismatch($sformatf("last_digit expected %0d got %0d",
                                         want.last_digit, rsp_ch.last_digit));
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   // Watchdog: end the run if no item moves on either channel for too long.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d digits owed",
               $realtime, STALL_LIMIT, digit_queue.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      reset        <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = SEND_IDLE[phase];
         rsp_idle_pct  = RSP_IDLE[phase];
         // walk the edge-value table once, in the first phase
         if (phase == 0) begin
            for (int row = 0; row < DIRECTED_ROWS; row++)
               send_value(directed_value[row], directed_text[row], 1'b0);
         end
         // drain at each phase start, and now and then at random
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_value(pick_value(), "", (n == 0) || ($urandom_range(49) == 0));
      end
      req_ch.valid <= 1'b0;

      // wait for every owed digit, then watch for stray extras
      while (digit_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (digit_queue.size() != 0)
         report_mismatch($sformatf("%0d digits never arrived", digit_queue.size()));

      $display("Converted %0d values (%0d from the edge table), checked %0d digits,",
               values_sent, DIRECTED_ROWS, digits_checked);
      $display("runs of %0d of %0d possible lengths, under three pacing profiles.",
               $countones(lengths_seen), MAX_DIGITS);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/bda_pkg.sv
hw/rtl/bda_channels.sv
hw/rtl/bda_dabble.sv
hw/rtl/bda_emit.sv
hw/rtl/binary_to_decimal_ascii.sv
tb/sv/tb_binary_to_decimal_ascii.sv
